### src/bte_pkg.sv
// ----------------------------------------------------------------------------
// bte_pkg
// Shared types and constants of the beat tempo median estimator.
// ----------------------------------------------------------------------------
package bte_pkg;

	localparam int RING_DEPTH_DEF = 8;

	localparam logic [15:0] VOLUME_GATE_RST = 16'd500;
	localparam logic [15:0] BASELINE_ALPHA_RST = 16'd1311;
	localparam logic [11:0] MIN_INTERVAL_RST = 12'd300;
	localparam logic [11:0] MAX_INTERVAL_RST = 12'd1200;

	// 100.0 in Q24.16.
	localparam logic [39:0] BASELINE_RST = 40'd6553600;

	// 60000 * 256, the tempo numerator.
	localparam logic [23:0] TEMPO_NUM = 24'd15360000;
	localparam logic [11:0] MEDIAN_FLOOR = 12'd50;
	localparam int MIN_INTERVALS = 3;

	localparam logic [1:0] REG_VOLUME_GATE = 2'd0;
	localparam logic [1:0] REG_BASELINE_ALPHA = 2'd1;
	localparam logic [1:0] REG_MIN_INTERVAL = 2'd2;
	localparam logic [1:0] REG_MAX_INTERVAL = 2'd3;

	typedef struct packed {
		logic [15:0] volume_gate;
		logic [15:0] baseline_alpha;
		logic [11:0] min_interval_ms;
		logic [11:0] max_interval_ms;
	} cfg_t;

	// One classified frame handed from the front to the back.
	typedef struct packed {
		logic [23:0] flux;
		logic        gated;
		logic        taken;
		logic [11:0] interval;
	} task_t;

endpackage

### src/bte_if.sv
// ----------------------------------------------------------------------------
// bte_if
// Valid/ready channels for input frames and result words.
// ----------------------------------------------------------------------------
interface bte_frame_if;
	logic        valid;
	logic        ready;
	logic [15:0] audio_level;
	logic [23:0] bass_power;
	logic        beat_flag;
	logic [31:0] time_ms;

	modport source(output valid, audio_level, bass_power, beat_flag, time_ms, input ready);
	modport sink(input valid, audio_level, bass_power, beat_flag, time_ms, output ready);
endinterface

interface bte_result_if;
	logic        valid;
	logic        ready;
	logic [23:0] flux;
	logic [23:0] flux_baseline;
	logic [15:0] tempo_q8;
	logic [3:0]  interval_total;
	logic        gated;
	logic        interval_taken;

	modport source(output valid, flux, flux_baseline, tempo_q8, interval_total, gated,
		interval_taken, input ready);
	modport sink(input valid, flux, flux_baseline, tempo_q8, interval_total, gated,
		interval_taken, output ready);
endinterface

### src/bte_front.sv
// ----------------------------------------------------------------------------
// bte_front
// Accepts frames, applies the gate, computes flux and classifies the beat.
// ----------------------------------------------------------------------------
module bte_front (
	input  logic               clk,
	input  logic               arst_n,
	bte_frame_if.sink          frame,
	input  bte_pkg::cfg_t      cfg,
	input  logic               full,
	output logic               push,
	output bte_pkg::task_t     word
);

	logic [23:0] prev_bass_q;
	logic [31:0] last_beat_q;
	logic        gated;
	logic [31:0] interval;

	assign frame.ready = !full;
	assign push = frame.valid && !full;

	assign gated = frame.audio_level < cfg.volume_gate;
	assign interval = frame.time_ms - last_beat_q;

	always_comb begin
		word.gated = gated;
		word.flux = (!gated && frame.bass_power > prev_bass_q) ?
			frame.bass_power - prev_bass_q : 24'd0;
		word.interval = interval[11:0];
		word.taken = !gated && frame.beat_flag && (last_beat_q != 32'd0)
			&& (interval >= {20'd0, cfg.min_interval_ms})
			&& (interval <= {20'd0, cfg.max_interval_ms});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_bass_q <= '0;
			last_beat_q <= '0;
		end else if (push) begin
			if (gated) begin
				prev_bass_q <= '0;
			end else begin
				prev_bass_q <= frame.bass_power;
				if (frame.beat_flag) begin
					last_beat_q <= frame.time_ms;
				end
			end
		end
	end

endmodule

### src/bte_fifo.sv
// ----------------------------------------------------------------------------
// bte_fifo
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module bte_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bte_pkg::task_t push_word,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output bte_pkg::task_t pop_word
);

	bte_pkg::task_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     count_q;

	assign full = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign pop_word = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### src/bte_back.sv
// ----------------------------------------------------------------------------
// bte_back
// Baseline update, interval ring, sorted median and serial tempo divide.
// ----------------------------------------------------------------------------
module bte_back #(
	parameter int RING_DEPTH = bte_pkg::RING_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bte_pkg::cfg_t  cfg,
	input  logic           task_valid,
	input  bte_pkg::task_t task_word,
	output logic           pop,
	bte_result_if.source   result
);

	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int POS_W = $clog2(RING_DEPTH);
	localparam int CNT_W = (FILL_W > 5) ? FILL_W : 5;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_LOAD, S_SORT, S_SHIFT, S_MED, S_DIV, S_TEMPO, S_OUT
	} state_t;

	state_t         state_q;
	bte_pkg::task_t task_q;
	logic [56:0]    keep_q;
	logic [55:0]    add_q;
	logic [39:0]    acc_q;
	logic [11:0]    ring_q [RING_DEPTH];
	logic [11:0]    sort_q [RING_DEPTH];
	logic [11:0]    sort_nxt [RING_DEPTH];
	logic [POS_W-1:0]  wpos_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_nxt;
	logic [FILL_W-1:0] shifts;
	logic [CNT_W-1:0]  cnt_q;
	logic [11:0]    med_q;
	logic [11:0]    median;
	logic [11:0]    rem_q;
	logic [12:0]    trial;
	logic [23:0]    num_q;
	logic [23:0]    quo_q;
	logic [15:0]    tempo_q;
	logic [57:0]    acc_sum;
	logic           res_valid_q;
	logic [23:0]    res_flux_q;
	logic [23:0]    res_base_q;
	logic [15:0]    res_tempo_q;
	logic [3:0]     res_total_q;
	logic           res_gated_q;
	logic           res_taken_q;

	assign pop = (state_q == S_IDLE) && task_valid;

	assign acc_sum = 58'(keep_q) + 58'(add_q);
	assign fill_nxt = (fill_q < FILL_W'(RING_DEPTH)) ? fill_q + 1'b1 : fill_q;
	assign shifts = (fill_q - 1'b1) >> 1;
	assign median = fill_q[0] ? sort_q[0] : 12'((13'(sort_q[0]) + 13'(sort_q[1])) >> 1);
	assign trial = {rem_q, num_q[23]};

	// Sort array next value: load with padding, transposition step, or shift down.
	always_comb begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			sort_nxt[i] = sort_q[i];
		end
		if (state_q == S_LOAD) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				sort_nxt[i] = (FILL_W'(i) < fill_q) ? ring_q[i] : 12'hFFF;
			end
		end else if (state_q == S_SORT) begin
			for (int i = 0; i < RING_DEPTH - 1; i++) begin
				if ((i % 2) == int'(cnt_q[0]) && sort_q[i] > sort_q[i+1]) begin
					sort_nxt[i] = sort_q[i+1];
					sort_nxt[i+1] = sort_q[i];
				end
			end
		end else if (state_q == S_SHIFT) begin
			for (int i = 0; i < RING_DEPTH - 1; i++) begin
				sort_nxt[i] = sort_q[i+1];
			end
			sort_nxt[RING_DEPTH-1] = 12'hFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			task_q <= task_word;
		end
		if (state_q == S_MUL) begin
			keep_q <= acc_q * (17'h10000 - 17'(cfg.baseline_alpha));
			add_q <= {40'(task_q.flux) * 40'(cfg.baseline_alpha), 16'd0};
		end
		if (state_q == S_ACC && task_q.taken) begin
			ring_q[wpos_q] <= task_q.interval;
		end
		for (int i = 0; i < RING_DEPTH; i++) begin
			sort_q[i] <= sort_nxt[i];
		end
		if (state_q == S_MED) begin
			med_q <= median;
			rem_q <= '0;
			num_q <= bte_pkg::TEMPO_NUM;
		end else if (state_q == S_DIV) begin
			num_q <= {num_q[22:0], 1'b0};
			if (trial >= {1'b0, med_q}) begin
				rem_q <= 12'(trial - {1'b0, med_q});
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial[11:0];
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
		if (state_q == S_OUT && (!res_valid_q || result.ready)) begin
			res_flux_q <= task_q.flux;
			res_base_q <= acc_q[39:16];
			res_tempo_q <= tempo_q;
			res_total_q <= (fill_q > FILL_W'(15)) ? 4'd15 : 4'(fill_q);
			res_gated_q <= task_q.gated;
			res_taken_q <= task_q.taken;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q <= bte_pkg::BASELINE_RST;
			wpos_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
			tempo_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (task_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= task_q.gated ? S_OUT : S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_sum[55:16];
					if (task_q.taken) begin
						wpos_q <= (wpos_q == POS_W'(RING_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
						fill_q <= fill_nxt;
						state_q <= (fill_nxt >= FILL_W'(bte_pkg::MIN_INTERVALS)) ?
							S_LOAD : S_OUT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_LOAD: begin
					cnt_q <= '0;
					state_q <= S_SORT;
				end
				S_SORT: begin
					if (cnt_q == CNT_W'(RING_DEPTH - 1)) begin
						cnt_q <= '0;
						state_q <= S_SHIFT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SHIFT: begin
					if (cnt_q == CNT_W'(shifts) - 1'b1) begin
						state_q <= S_MED;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MED: begin
					cnt_q <= '0;
					state_q <= (median <= bte_pkg::MEDIAN_FLOOR) ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(23)) begin
						state_q <= S_TEMPO;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TEMPO: begin
					tempo_q <= (quo_q > 24'd65535) ? 16'hFFFF : quo_q[15:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.flux = res_flux_q;
	assign result.flux_baseline = res_base_q;
	assign result.tempo_q8 = res_tempo_q;
	assign result.interval_total = res_total_q;
	assign result.gated = res_gated_q;
	assign result.interval_taken = res_taken_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("interval fill count beyond ring depth");
	a_sort_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SORT) |-> (fill_q >= FILL_W'(bte_pkg::MIN_INTERVALS)))
		else $error("median sort started with too few intervals");
	a_tempo_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		(tempo_q != $past(tempo_q)) |-> ($past(state_q) == S_TEMPO))
		else $error("tempo changed outside the divide result step");
`endif

endmodule

### src/beat_tempo_median_estimator_unit.sv
// ----------------------------------------------------------------------------
// beat_tempo_median_estimator_unit
// Gated bass flux, EMA baseline and median inter-beat tempo per audio frame.
// ----------------------------------------------------------------------------
// A gated frame passes the idle, multiply and output states; any other frame also
// passes the accumulate state. A stored interval with three or more in the ring
// adds the load, sort, shift and median states, plus the restoring divide and
// saturation unless the median is 50 ms or less.
// The back end handles one frame at a time. Reset clears all control state;
// registers take their defaults.
module beat_tempo_median_estimator_unit #(
	parameter int RING_DEPTH = bte_pkg::RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bte_frame_if.sink   frame,
	bte_result_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bte_pkg::cfg_t  cfg_q;
	bte_pkg::task_t push_word;
	bte_pkg::task_t pop_word;
	logic           push;
	logic           pop;
	logic           full;
	logic           not_empty;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_gate <= bte_pkg::VOLUME_GATE_RST;
			cfg_q.baseline_alpha <= bte_pkg::BASELINE_ALPHA_RST;
			cfg_q.min_interval_ms <= bte_pkg::MIN_INTERVAL_RST;
			cfg_q.max_interval_ms <= bte_pkg::MAX_INTERVAL_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				bte_pkg::REG_VOLUME_GATE: cfg_q.volume_gate <= pwdata[15:0];
				bte_pkg::REG_BASELINE_ALPHA: cfg_q.baseline_alpha <= pwdata[15:0];
				bte_pkg::REG_MIN_INTERVAL: cfg_q.min_interval_ms <= pwdata[11:0];
				bte_pkg::REG_MAX_INTERVAL: cfg_q.max_interval_ms <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bte_pkg::REG_VOLUME_GATE: prdata = {16'd0, cfg_q.volume_gate};
			bte_pkg::REG_BASELINE_ALPHA: prdata = {16'd0, cfg_q.baseline_alpha};
			bte_pkg::REG_MIN_INTERVAL: prdata = {20'd0, cfg_q.min_interval_ms};
			bte_pkg::REG_MAX_INTERVAL: prdata = {20'd0, cfg_q.max_interval_ms};
			default: prdata = '0;
		endcase
	end

	bte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.cfg    (cfg_q),
		.full   (full),
		.push   (push),
		.word   (push_word)
	);

	bte_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.pop_word  (pop_word)
	);

	bte_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.task_valid (not_empty),
		.task_word  (pop_word),
		.pop        (pop),
		.result     (result)
	);

endmodule
